@@ sv/uaphd_pkg.sv @@
// Shared types, constants and a helper function for the hop distance block.
// Used by the channel interfaces, the adjacency store and the top level.
package uaphd_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int DIST_W    = 6;
  localparam int PAIR_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam int POWER_MAX = 63;
  localparam int CHUNK_W   = 8;
  localparam int NCHUNK    = MAX_NODES / CHUNK_W;

  typedef logic [MAX_NODES-1:0] row_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [NODE_W:0]      count_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [PAIR_W-1:0]    pair_t;
  typedef dist_t [MAX_NODES-1:0] dist_row_t;
  typedef logic [$clog2(CHUNK_W+1)-1:0] chunk_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT     = 2'd0,
    CFG_UNDIRECTED     = 2'd1,
    CFG_DIAMETER_LIMIT = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    KIND_DONE   = 1'b0,
    KIND_ANSWER = 1'b1
  } kind_t;

  // One row write into the adjacency store.
  typedef struct packed {
    logic  valid;
    logic  clear;
    node_t row;
    row_t  bits;
    logic  mirror;
  } adj_load_t;

  // Direct edges of a row, and edges loaded at this row that are mirrored
  // (the mirrored part is kept transposed: bit j means an edge j -> row).
  typedef struct packed {
    row_t direct;
    row_t mirrored;
  } adj_word_t;

  function automatic chunk_cnt_t popcount8(input logic [CHUNK_W-1:0] v);
    chunk_cnt_t c;
    c = '0;
    for (int b = 0; b < CHUNK_W; b++) begin
      c = c + chunk_cnt_t'(v[b]);
    end
    return c;
  endfunction

endpackage

@@ sv/uaphd_in_if.sv @@
// Input channel of the hop distance block: load rows and distance queries.
// Depends on uaphd_pkg.
interface uaphd_in_if;
  import uaphd_pkg::*;
  logic  valid;
  logic  ready;
  logic  operation;
  node_t row_index;
  row_t  row_bits;
  node_t target_node;
  logic  last_row;

  modport source (output valid, output operation, output row_index, output row_bits,
                  output target_node, output last_row, input ready);
  modport sink (input valid, input operation, input row_index, input row_bits,
                input target_node, input last_row, output ready);
endinterface

@@ sv/uaphd_out_if.sv @@
// Output channel of the hop distance block: completion and query answers.
// Depends on uaphd_pkg.
interface uaphd_out_if;
  import uaphd_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  dist_t distance;
  pair_t pairs_found;

  modport source (output valid, output kind, output distance, output pairs_found,
                  input ready);
  modport sink (input valid, input kind, input distance, input pairs_found,
                output ready);
endinterface

@@ sv/uaphd_adj_store.sv @@
// Adjacency memory with per-row valid bits and a read-modify-write path
// for row loads, forwarding the previous write. Depends on uaphd_pkg.
module uaphd_adj_store (
  input  logic                 clk,
  input  logic                 rst,
  input  uaphd_pkg::adj_load_t ld,
  input  logic                 rd_en,
  input  uaphd_pkg::node_t     rd_addr,
  output uaphd_pkg::adj_word_t rd_word
);
  import uaphd_pkg::*;

  adj_word_t mem [MAX_NODES];
  row_t      row_ok;
  adj_word_t rdata;
  logic      rvalid;
  adj_load_t pend;
  logic      fwd_v;
  node_t     fwd_row;
  adj_word_t fwd_word;
  node_t     addr;
  adj_word_t base;
  adj_word_t wr_word;

  assign addr = ld.valid ? ld.row : rd_addr;

  always_comb begin
    if (fwd_v && fwd_row == pend.row) begin
      base = fwd_word;
    end else if (rvalid) begin
      base = rdata;
    end else begin
      base = '0;
    end
    wr_word.direct   = base.direct | pend.bits;
    wr_word.mirrored = base.mirrored | (pend.mirror ? pend.bits : '0);
  end

  assign rd_word = rvalid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (ld.valid || rd_en) begin
      rdata <= mem[addr];
    end
    if (pend.valid) begin
      mem[pend.row] <= wr_word;
    end
    fwd_row  <= pend.row;
    fwd_word <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok     <= '0;
      rvalid     <= 1'b0;
      pend.valid <= 1'b0;
      fwd_v      <= 1'b0;
    end else begin
      if (ld.valid || rd_en) begin
        rvalid <= ld.clear ? 1'b0 : row_ok[addr];
      end
      if (ld.clear) begin
        row_ok <= '0;
      end
      if (pend.valid) begin
        row_ok[pend.row] <= 1'b1;
      end
      pend.valid <= ld.valid;
      fwd_v      <= pend.valid;
    end
    pend.clear  <= ld.clear;
    pend.row    <= ld.row;
    pend.bits   <= ld.bits;
    pend.mirror <= ld.mirror;
  end

endmodule

@@ sv/unweighted_all_pairs_hop_distance.sv @@
// Top level of the all-pairs hop distance block (boolean matrix powers).
// Depends on uaphd_pkg, uaphd_in_if, uaphd_out_if and uaphd_adj_store.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        operation, row_index, row_bits, target_node, last_row
//   out_ch    out  valid/ready        kind, distance, pairs_found
//   cfg       in   cfg_we (no ready)  cfg_index, cfg_data
//
// Loads and queries are taken one per cycle while the block is idle and no pending
// query answer is waiting for the output register. A query answer is read from the
// distance memory into the query stage, then enters the output register when it can move.
// The final load row starts the computation: a setup step, then per power and per
// row a fetch, one adjacency memory read per active node, a drain of the read
// pipeline, an update and a count step, and a check step at the end of each power;
// the completion item waits for the output register. No item is taken until the
// completion item has entered the output register.
// Reset is synchronous and clears control and configuration state only; the memories keep their
// contents and are qualified by valid bits and a distance-valid flag.
module unweighted_all_pairs_hop_distance (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [uaphd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [uaphd_pkg::CFG_W-1:0]           cfg_data,
  uaphd_in_if.sink                              in_ch,
  uaphd_out_if.source                           out_ch
);
  import uaphd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_CNT   = 7'b0100000,
    S_CHK   = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [CFG_W-1:0] node_count;
  logic             undirected;
  dist_t            diameter_limit;

  state_t state;
  logic   in_acc, is_load, is_query, new_load, out_move;
  logic   finished, dist_ok;
  count_t n_cur, n_act, n_done;
  row_t   mask;
  pair_t  kmax, pair_cnt;
  dist_t  power;
  node_t  row_i;
  count_t s_cnt;
  logic   rd_en, rd_pend;
  node_t  rd_s;
  row_t   acc;
  logic   fresh_any;
  logic   done_fire;

  // Query stage between the distance memory read and the output register.
  logic   q_pend, q_ok;
  node_t  q_tgt;
  pair_t  q_pair;

  // Output register.
  logic   out_valid;
  logic   out_kind;
  dist_t  out_dist;
  pair_t  out_pairs;

  // Memories: distance rows and reach rows, one row per source node.
  dist_row_t dist_mem [MAX_NODES];
  dist_row_t dist_rd;
  row_t      reach_mem [MAX_NODES];
  row_t      reach_rd;

  adj_load_t  ld;
  adj_word_t  adj_word;
  row_t       reach_cur, acc_next, fresh;
  dist_row_t  dist_new;
  chunk_cnt_t chunk_cnt [NCHUNK];
  count_t     fresh_sum;
  logic       stop;

  assign n_cur    = (node_count > CFG_W'(MAX_NODES)) ? count_t'(MAX_NODES)
                                                     : count_t'(node_count);
  assign out_move = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && (!q_pend || out_move);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_load  = in_acc && (in_ch.operation == OP_LOAD);
  assign is_query = in_acc && (in_ch.operation == OP_QUERY);
  assign new_load = is_load && finished;

  assign ld.valid  = is_load;
  assign ld.clear  = new_load;
  assign ld.row    = in_ch.row_index;
  assign ld.bits   = in_ch.row_bits;
  assign ld.mirror = undirected;

  assign rd_en = (state == S_ACC) && (s_cnt < n_act);

  uaphd_adj_store u_adj (
    .clk     (clk),
    .rst     (rst),
    .ld      (ld),
    .rd_en   (rd_en),
    .rd_addr (s_cnt[NODE_W-1:0]),
    .rd_word (adj_word)
  );

  // At the first power the reach row is the identity row, so that the product
  // yields the (masked, mirrored) adjacency row itself.
  always_comb begin
    reach_cur = reach_rd;
    if (power == dist_t'(1)) begin
      reach_cur = '0;
      reach_cur[row_i] = 1'b1;
    end
  end

  // One step of the boolean product: row rd_s of the adjacency contributes its
  // direct edges if reached, and the mirrored edges stored transposed give
  // bit rd_s directly.
  always_comb begin
    acc_next = acc;
    if (reach_cur[rd_s]) begin
      acc_next = acc_next | (adj_word.direct & mask);
    end
    if (|(reach_cur & adj_word.mirrored & mask)) begin
      acc_next[rd_s] = 1'b1;
    end
  end

  // A pair is new when reached, off the diagonal, and still without distance.
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      fresh[j] = acc[j] && (node_t'(j) != row_i) &&
                 ((power == dist_t'(1)) || (dist_rd[j] == '0));
      if (fresh[j]) begin
        dist_new[j] = power;
      end else if (power == dist_t'(1)) begin
        dist_new[j] = '0;
      end else begin
        dist_new[j] = dist_rd[j];
      end
    end
  end

  always_comb begin
    fresh_sum = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      fresh_sum = fresh_sum + count_t'(chunk_cnt[c]);
    end
  end

  assign stop = ((power != dist_t'(1)) && !fresh_any) || (pair_cnt >= kmax) ||
                ((diameter_limit != '0) && (power >= diameter_limit)) ||
                (power >= dist_t'(POWER_MAX));

  assign done_fire = (state == S_CHK) && stop && !q_pend && out_move;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (is_query) begin
      dist_rd <= dist_mem[in_ch.row_index];
    end else if (state == S_FETCH) begin
      dist_rd  <= dist_mem[row_i];
      reach_rd <= reach_mem[row_i];
    end
    if (state == S_UPD) begin
      dist_mem[row_i]  <= dist_new;
      reach_mem[row_i] <= acc;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        mask[j] <= count_t'(j) < n_cur;
      end
      kmax <= PAIR_W'(n_cur) * PAIR_W'(n_cur - count_t'(1));
    end
    if (state == S_FETCH) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc_next;
    end
    rd_s <= s_cnt[NODE_W-1:0];
    if (state == S_UPD) begin
      for (int c = 0; c < NCHUNK; c++) begin
        chunk_cnt[c] <= popcount8(fresh[c*CHUNK_W +: CHUNK_W]);
      end
    end
    if (is_query) begin
      q_ok  <= dist_ok && (count_t'(in_ch.row_index) < n_done) &&
               (count_t'(in_ch.target_node) < n_done) &&
               (count_t'(in_ch.row_index) < n_cur) &&
               (count_t'(in_ch.target_node) < n_cur);
      q_tgt  <= in_ch.target_node;
      q_pair <= pair_cnt;
    end
    if (q_pend && out_move) begin
      out_kind  <= KIND_ANSWER;
      out_dist  <= q_ok ? dist_rd[q_tgt] : '0;
      out_pairs <= q_pair;
    end else if (done_fire) begin
      out_kind  <= KIND_DONE;
      out_dist  <= '0;
      out_pairs <= pair_cnt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= CFG_W'(MAX_NODES);
      undirected     <= 1'b0;
      diameter_limit <= '0;
      state          <= S_IDLE;
      finished       <= 1'b0;
      dist_ok        <= 1'b0;
      n_act          <= '0;
      n_done         <= '0;
      pair_cnt       <= '0;
      power          <= dist_t'(1);
      row_i          <= '0;
      s_cnt          <= '0;
      rd_pend        <= 1'b0;
      fresh_any      <= 1'b0;
      q_pend         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT:     node_count     <= cfg_data;
          CFG_UNDIRECTED:     undirected     <= cfg_data[0];
          CFG_DIAMETER_LIMIT: diameter_limit <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end

      if (is_query) begin
        q_pend <= 1'b1;
      end else if (q_pend && out_move) begin
        q_pend <= 1'b0;
      end

      if ((q_pend && out_move) || done_fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (new_load) begin
        finished <= 1'b0;
        dist_ok  <= 1'b0;
        pair_cnt <= '0;
        power    <= dist_t'(1);
      end

      rd_pend <= rd_en;

      unique case (state)
        S_IDLE: begin
          if (is_load && in_ch.last_row) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (!q_pend) begin
            n_act     <= n_cur;
            pair_cnt  <= '0;
            power     <= dist_t'(1);
            row_i     <= '0;
            fresh_any <= 1'b0;
            dist_ok   <= 1'b0;
            // With no nodes the computation ends at once with no pairs.
            state     <= (n_cur == '0) ? S_CHK : S_FETCH;
          end
        end
        S_FETCH: begin
          s_cnt <= '0;
          state <= S_ACC;
        end
        S_ACC: begin
          if (rd_en) begin
            s_cnt <= s_cnt + count_t'(1);
          end else if (!rd_pend) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          fresh_any <= fresh_any | (|fresh);
          state     <= S_CNT;
        end
        S_CNT: begin
          pair_cnt <= pair_cnt + PAIR_W'(fresh_sum);
          if (count_t'(row_i) + count_t'(1) == n_act) begin
            state <= S_CHK;
          end else begin
            row_i <= row_i + node_t'(1);
            state <= S_FETCH;
          end
        end
        S_CHK: begin
          if (stop) begin
            if (done_fire) begin
              finished <= 1'b1;
              dist_ok  <= 1'b1;
              n_done   <= n_act;
              state    <= S_IDLE;
            end
          end else begin
            power     <= power + dist_t'(1);
            row_i     <= '0;
            fresh_any <= 1'b0;
            state     <= S_FETCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_kind;
  assign out_ch.distance    = out_dist;
  assign out_ch.pairs_found = out_pairs;

endmodule
